>>> hw/rtl/est_pkg.sv
// shared constants and codes of the endpoint set table
package est_pkg;

  // table size and derived widths
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned ENTRY_W  = ADDR_W + PORT_W;

  // request kinds (the reserved code behaves as a lookup)
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

>>> hw/rtl/est_ram.sv
// generic single write port ram with registered read
module est_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/endpoint_set_table.sv
// endpoint set table: insert, delete and lookup of address/port pairs
//
//  channel | direction | payload                               | handshake
//  in      | input     | req_type, client_addr, client_port    | in_valid_i / in_stall_o
//  out     | output    | status, entry_count                   | out_valid_o / out_stall_i
//
// each request reads every slot in turn through the single read port of the entry ram,
// compares each slot after its read, and then commits; the next transfer is taken in the
// idle state after the commit, so the block takes no new transfer while a request is in
// its scan or commit.
// the valid marks and entry count are cleared by reset; the ram needs no clearing.
// a finished result waits in the output register; the block takes the next
// transfer while it waits, but holds a new commit until the register is free.
module endpoint_set_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [est_pkg::REQ_W-1:0]         req_type_i,
  input  logic [est_pkg::ADDR_W-1:0]        client_addr_i,
  input  logic [est_pkg::PORT_W-1:0]        client_port_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [est_pkg::STATUS_W-1:0]      status_o,
  output logic [est_pkg::COUNT_W-1:0]       entry_count_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  localparam logic [est_pkg::CNT_W-1:0] CNT_END = est_pkg::CNT_W'(est_pkg::TABLE_DEPTH);

  logic [1:0]                         state_q, state_d;
  logic [est_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic                               chk_q, chk_d;
  logic [est_pkg::IDX_W-1:0]          chk_idx_q, chk_idx_d;
  logic                               hit_q, hit_d;
  logic [est_pkg::IDX_W-1:0]          hit_idx_q, hit_idx_d;
  logic                               free_q, free_d;
  logic [est_pkg::IDX_W-1:0]          free_idx_q, free_idx_d;
  logic [est_pkg::REQ_W-1:0]          req_q;
  logic [est_pkg::ENTRY_W-1:0]        key_q;
  logic [est_pkg::TABLE_DEPTH-1:0]    valid_q;
  logic [est_pkg::COUNT_W-1:0]        total_q, total_d;
  logic                               out_valid_q, out_valid_d;
  logic [est_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [est_pkg::COUNT_W-1:0]        count_q, count_d;

  logic                               in_xfer;
  logic                               rd_en;
  logic [est_pkg::ENTRY_W-1:0]        rd_data;
  logic                               wr_en;
  logic                               set_valid;
  logic                               clr_valid;
  logic                               commit;
  logic                               slot_match;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // entry storage, one address/port pair per slot
  est_ram #(
    .WIDTH (est_pkg::ENTRY_W),
    .DEPTH (est_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (free_idx_q),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[est_pkg::IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_en = (state_q == S_SCAN) && (cnt_q != CNT_END);
  assign slot_match = valid_q[chk_idx_q] && (rd_data == key_q);
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  // scan sequencer and commit decision
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    chk_d       = 1'b0;
    chk_idx_d   = cnt_q[est_pkg::IDX_W-1:0];
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    total_d     = total_q;
    status_d    = status_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        // compare the slot read in the previous cycle
        if (chk_q) begin
          if (slot_match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
          end
          if (!valid_q[chk_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
        end
        if (cnt_q == CNT_END) begin
          state_d = S_COMMIT;
        end else begin
          chk_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          status_d    = est_pkg::ST_NONE;
          case (req_q)
            est_pkg::REQ_INSERT: begin
              if (!hit_q) begin
                if (free_q) begin
                  wr_en     = 1'b1;
                  set_valid = 1'b1;
                  total_d   = total_q + 1'b1;
                  status_d  = est_pkg::ST_DONE;
                end else begin
                  status_d = est_pkg::ST_FULL;
                end
              end
            end
            est_pkg::REQ_DELETE: begin
              if (hit_q) begin
                clr_valid = 1'b1;
                total_d   = total_q - 1'b1;
                status_d  = est_pkg::ST_DONE;
              end
            end
            default: begin
              status_d = hit_q ? est_pkg::ST_DONE : est_pkg::ST_NONE;
            end
          endcase
          count_d = total_d;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // valid marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (set_valid) begin
      valid_q[free_idx_q] <= 1'b1;
    end else if (clr_valid) begin
      valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= req_type_i;
      key_q <= {client_addr_i, client_port_i};
    end
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    count_q    <= count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

>>> tb/sv/endpoint_set_table_tb.sv
// testbench of the endpoint set table: directed and random request traffic checked against a table model
`timescale 1ns / 1ps

module endpoint_set_table_tb;

  // the reserved request kind, which the block treats as a lookup
  localparam logic [est_pkg::REQ_W-1:0] REQ_RESERVED = 2'd3;
  localparam int unsigned FILL_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 125;

  typedef struct packed {
    logic [est_pkg::REQ_W-1:0]  kind;
    logic [est_pkg::ADDR_W-1:0] addr;
    logic [est_pkg::PORT_W-1:0] port;
  } endpoint_req_t;

  typedef struct packed {
    logic [est_pkg::STATUS_W-1:0] status;
    logic [est_pkg::COUNT_W-1:0]  count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [est_pkg::REQ_W-1:0] req_type_i = '0;
  logic [est_pkg::ADDR_W-1:0] client_addr_i = '0;
  logic [est_pkg::PORT_W-1:0] client_port_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [est_pkg::STATUS_W-1:0] status_o;
  logic [est_pkg::COUNT_W-1:0] entry_count_o;

  // model of the stored set
  logic                          set_valid [est_pkg::TABLE_DEPTH];
  logic [est_pkg::ADDR_W-1:0]    set_addr [est_pkg::TABLE_DEPTH];
  logic [est_pkg::PORT_W-1:0]    set_port [est_pkg::TABLE_DEPTH];
  logic [est_pkg::COUNT_W-1:0]   set_total;

  endpoint_req_t pending_reqs [$];
  endpoint_req_t known_endpoints [$];
  table_result_t expected_results [$];
  int unsigned   mismatches = 0;
  int unsigned   gap_left = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_window = 0;
  int unsigned   stall_pct = 0;

  endpoint_set_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .client_addr_i (client_addr_i),
    .client_port_i (client_port_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  // apply one request to the model and return the result it should give
  function automatic table_result_t apply_request(endpoint_req_t req);
    table_result_t res;
    int hit_idx;
    int free_idx;
    hit_idx = -1;
    free_idx = -1;
    for (int i = est_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (set_valid[i] && set_addr[i] == req.addr && set_port[i] == req.port) hit_idx = i;
      if (!set_valid[i]) free_idx = i;
    end
    res.status = est_pkg::ST_NONE;
    case (req.kind)
      est_pkg::REQ_INSERT: begin
        if (hit_idx < 0) begin
          if (free_idx >= 0) begin
            set_valid[free_idx] = 1'b1;
            set_addr[free_idx] = req.addr;
            set_port[free_idx] = req.port;
            set_total = set_total + 1'b1;
            res.status = est_pkg::ST_DONE;
          end else begin
            res.status = est_pkg::ST_FULL;
          end
        end
      end
      est_pkg::REQ_DELETE: begin
        if (hit_idx >= 0) begin
          set_valid[hit_idx] = 1'b0;
          if (set_total != 0) set_total = set_total - 1'b1;
          res.status = est_pkg::ST_DONE;
        end
      end
      default: begin
        if (hit_idx >= 0) res.status = est_pkg::ST_DONE;
      end
    endcase
    res.count = set_total;
    return res;
  endfunction

  // a new endpoint, often sharing its address or port with a known one
  function automatic endpoint_req_t fresh_endpoint();
    endpoint_req_t ep;
    int unsigned sel;
    ep.kind = est_pkg::REQ_INSERT;
    ep.addr = $urandom;
    ep.port = est_pkg::PORT_W'($urandom);
    if (known_endpoints.size() > 0) begin
      sel = $urandom_range(0, known_endpoints.size() - 1);
      case ($urandom_range(0, 9))
        0, 1: ep.addr = known_endpoints[sel].addr;
        2, 3: ep.port = known_endpoints[sel].port;
        4: ep.addr = '1;
        5: ep.port = '0;
        default: ;
      endcase
    end
    return ep;
  endfunction

  function automatic endpoint_req_t known_endpoint(bit remove);
    endpoint_req_t ep;
    int unsigned sel;
    if (known_endpoints.size() == 0) return fresh_endpoint();
    sel = $urandom_range(0, known_endpoints.size() - 1);
    ep = known_endpoints[sel];
    if (remove) known_endpoints.delete(sel);
    return ep;
  endfunction

  task automatic push_req(logic [est_pkg::REQ_W-1:0] kind, logic [est_pkg::ADDR_W-1:0] addr,
                          logic [est_pkg::PORT_W-1:0] port);
    endpoint_req_t req;
    req.kind = kind;
    req.addr = addr;
    req.port = port;
    pending_reqs.push_back(req);
  endtask

  // driver: bursts of transfers with random gaps, predicting each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    endpoint_req_t req;
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        req.kind = req_type_i;
        req.addr = client_addr_i;
        req.port = client_port_i;
        expected_results.push_back(apply_request(req));
        next_valid = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          case ($urandom_range(0, 3))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(1, 10);
            default: gap_left = $urandom_range(10, 150);
          endcase
        end
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          req_type_i <= req.kind;
          client_addr_i <= req.addr;
          client_port_i <= req.port;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // receiver stall: a random stall rate that changes from window to window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_window = $urandom_range(50, 600);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_window--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    table_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d count %0d",
                 $time, status_o, entry_count_o);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_res.status, status_o);
          mismatches++;
        end
        if (entry_count_o !== exp_res.count) begin
          $display("%0t: entry count mismatch, expected %0d, actual %0d",
                   $time, exp_res.count, entry_count_o);
          mismatches++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    endpoint_req_t ep;
    int unsigned roll;
    bit fill_phase;
    for (int i = 0; i < est_pkg::TABLE_DEPTH; i++) begin
      set_valid[i] = 1'b0;
      set_addr[i] = '0;
      set_port[i] = '0;
    end
    set_total = '0;

    // directed: empty table, extremes, duplicates, reserved kind, slot reuse
    push_req(est_pkg::REQ_LOOKUP, '0, '0);
    push_req(est_pkg::REQ_DELETE, '0, '0);
    push_req(est_pkg::REQ_INSERT, '0, '0);
    push_req(est_pkg::REQ_INSERT, '0, '0);
    push_req(est_pkg::REQ_LOOKUP, '0, '0);
    push_req(est_pkg::REQ_INSERT, '1, '1);
    push_req(REQ_RESERVED, '1, '1);
    push_req(REQ_RESERVED, 32'h0000_0001, 16'h0001);
    push_req(est_pkg::REQ_INSERT, '1, '0);
    push_req(est_pkg::REQ_INSERT, '0, '1);
    push_req(est_pkg::REQ_LOOKUP, 32'h8000_0000, 16'h8000);
    push_req(est_pkg::REQ_LOOKUP, '1, 16'hfffe);
    push_req(est_pkg::REQ_DELETE, '1, '1);
    push_req(est_pkg::REQ_DELETE, '1, '1);
    push_req(est_pkg::REQ_INSERT, 32'h1234_5678, 16'habcd);
    push_req(est_pkg::REQ_LOOKUP, '1, '0);
    push_req(est_pkg::REQ_DELETE, '0, '0);
    push_req(est_pkg::REQ_DELETE, '1, '0);
    push_req(est_pkg::REQ_DELETE, '0, '1);
    push_req(est_pkg::REQ_DELETE, 32'h1234_5678, 16'habcd);
    push_req(est_pkg::REQ_LOOKUP, 32'h1234_5678, 16'habcd);

    // random: fill phases run the table into full, drain phases delete more often than they insert
    for (int phase = 0; phase < FILL_PHASES; phase++) begin
      fill_phase = (phase % 2 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          ep = ($urandom_range(0, 1) == 0) ? known_endpoint(1'b0) : fresh_endpoint();
          ep.kind = REQ_RESERVED;
        end else begin
          roll = $urandom_range(0, 99);
          if ((fill_phase && roll < 80) || (!fill_phase && roll < 25)) begin
            if ($urandom_range(0, 99) < 85) begin
              ep = fresh_endpoint();
              known_endpoints.push_back(ep);
              if (known_endpoints.size() > 80) void'(known_endpoints.pop_front());
            end else begin
              ep = known_endpoint(1'b0);
            end
            ep.kind = est_pkg::REQ_INSERT;
          end else if ((fill_phase && roll < 90) || (!fill_phase && roll < 75)) begin
            ep = ($urandom_range(0, 99) < 85) ? known_endpoint(1'b1) : fresh_endpoint();
            ep.kind = est_pkg::REQ_DELETE;
          end else begin
            ep = ($urandom_range(0, 1) == 0) ? known_endpoint(1'b0) : fresh_endpoint();
            ep.kind = est_pkg::REQ_LOOKUP;
          end
        end
        pending_reqs.push_back(ep);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (est_pkg::TABLE_DEPTH + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("endpoint_set_table_tb passed");
    end else begin
      $display("endpoint_set_table_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("endpoint_set_table_tb failed");
    $finish;
  end

endmodule
